/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on the rising edge and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/i2bn_pkg.sv */
package i2bn_pkg;

	localparam int BASE_W  = 6;
	localparam int CAP_W   = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;
	localparam int LEN_W   = 6;

	localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
	localparam logic [BASE_W-1:0] MAX_BASE = 6'd62;

	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'd0;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// digit value to its character in 0-9, A-Z, a-z; codes past the alphabet wrap
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		logic [CHAR_W-1:0] ch;
		dw = CHAR_W'(d);
		if (d < 6'd10) begin
			ch = CHAR_ZERO + dw;
		end else if (d < 6'd36) begin
			ch = CHAR_UPPER + dw - 7'd10;
		end else if (d < 6'd62) begin
			ch = CHAR_LOWER + dw - 7'd36;
		end else begin
			ch = CHAR_ZERO + dw - 7'd62;
		end
		return ch;
	endfunction

endpackage

/* hw/rtl/i2bn_req_if.sv */
interface i2bn_req_if #(
	parameter int VALUE_BITS = 32
);
	import i2bn_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic [BASE_W-1:0]            base;
	logic [CAP_W-1:0]             capacity;
	logic                         count_only;

	modport source (output valid, output value, output base, output capacity,
		output count_only, input ready);
	modport sink (input valid, input value, input base, input capacity,
		input count_only, output ready);
endinterface

/* hw/rtl/i2bn_rsp_if.sv */
interface i2bn_rsp_if;
	import i2bn_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;
	logic [LEN_W-1:0]  length;
	logic              status;

	modport source (output valid, output char_code, output is_last, output length,
		output status, input ready);
	modport sink (input valid, input char_code, input is_last, input length,
		input status, output ready);
endinterface

/* hw/rtl/i2bn_divider.sv */
module i2bn_divider #(
	parameter int VALUE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  i2bn_pkg::div_ctl_t             ctl,
	input  logic [VALUE_BITS-1:0]          dividend,
	input  logic [i2bn_pkg::BASE_W-1:0]    divisor,
	output i2bn_pkg::div_sts_t             sts,
	output logic [VALUE_BITS-1:0]          quotient,
	output logic [i2bn_pkg::DIGIT_W-1:0]   remainder
);
	import i2bn_pkg::*;

	localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BASE_W-1:0]     div_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIGIT_W:0] trial;
	logic             fits;

	// restoring division, one quotient bit per cycle, msb first
	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? DIGIT_W'(trial - {1'b0, div_q}) : trial[DIGIT_W-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

/* hw/rtl/int_to_base_n_digit_string_unit.sv */
// channel  dir  fields                                   handshake
// req      in   value, base, capacity, count_only        valid / ready
// rsp      out  char_code, is_last, length, status       valid / ready
//
// one request at a time: the next is accepted only once the last word of the answer is in the
// output register; each digit is one pass of the shared bit-serial divider, one quotient bit a
// cycle, and the finished pass hands its quotient back in the same cycle as the next pass starts
// words leave one per cycle through an output register; a stalled rsp holds the sequencer
// a bad base is answered without dividing; arst_n returns the unit to idle at once
`include "assert_macros.svh"

module int_to_base_n_digit_string_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	i2bn_req_if.sink   req,
	i2bn_rsp_if.source rsp
);
	import i2bn_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int IDX_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int CMP_W = CNT_W + CAP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_DECIDE,
		S_SINGLE,
		S_SIGN,
		S_DIGIT
	} state_t;

	state_t state_q;

	logic                  neg_q;
	logic [BASE_W-1:0]     base_q;
	logic [CAP_W-1:0]      cap_q;
	logic                  conly_q;
	logic                  reject_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      idx_q;
	logic [DIGIT_W-1:0]    store_q [VALUE_BITS];

	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  out_status_q;

	div_ctl_t              div_ctl;
	div_sts_t              div_sts;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [BASE_W-1:0]     div_divisor;
	logic [VALUE_BITS-1:0] div_quot;
	logic [DIGIT_W-1:0]    div_rem;

	logic [VALUE_BITS-1:0] value_u;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  base_ok;
	logic                  req_fire;
	logic [CNT_W-1:0]      n_next;
	logic                  more_digits;
	logic                  too_long;
	logic                  slot_free;
	logic                  emit;
	logic [CHAR_W-1:0]     item_char;
	logic                  item_last;
	logic [LEN_W-1:0]      item_len;
	logic                  item_status;
	logic [DIGIT_W-1:0]    rd_digit;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	always_comb begin
		value_u     = req.value;
		mag_in      = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
		base_ok     = (req.base >= MIN_BASE) && (req.base <= MAX_BASE);
		n_next      = n_q + CNT_W'(1);
		more_digits = (div_quot != '0) && (n_next < CNT_W'(VALUE_BITS));
		too_long    = CMP_W'(n_q) > CMP_W'(cap_q);
	end

	// first division starts on accepting a request with a good base, the rest chain off the previous quotient
	always_comb begin
		div_ctl.start = (req_fire && base_ok)
			|| (state_q == S_DIV && div_sts.done && more_digits);
		div_dividend  = (state_q == S_IDLE) ? mag_in : div_quot;
		div_divisor   = (state_q == S_IDLE) ? req.base : base_q;
	end

	i2bn_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// digit stack, least significant digit at the bottom
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_sts.done) begin
			store_q[n_q[IDX_W-1:0]] <= div_rem;
		end
	end

	assign rd_digit = store_q[IDX_W'(idx_q - CNT_W'(1))];

	always_comb begin
		item_char   = CHAR_NONE;
		item_last   = 1'b0;
		item_len    = '0;
		item_status = STATUS_OK;
		case (state_q)
			S_SINGLE: begin
				item_last   = 1'b1;
				item_len    = reject_q ? '0 : LEN_W'(n_q);
				item_status = reject_q ? STATUS_REJECT : STATUS_OK;
			end
			S_SIGN: begin
				item_char = CHAR_MINUS;
			end
			S_DIGIT: begin
				item_char = digit_char(rd_digit);
				item_last = (idx_q == CNT_W'(1));
				item_len  = item_last ? LEN_W'(n_q + CNT_W'(neg_q)) : '0;
			end
			default: begin
			end
		endcase
	end

	assign slot_free = !out_valid_q || rsp.ready;
	assign emit      = slot_free
		&& (state_q == S_SINGLE || state_q == S_SIGN || state_q == S_DIGIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			n_q         <= '0;
			idx_q       <= '0;
			reject_q    <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						neg_q    <= value_u[VALUE_BITS-1];
						n_q      <= '0;
						reject_q <= !base_ok;
						state_q  <= base_ok ? S_DIV : S_SINGLE;
					end
				end
				S_DIV: begin
					if (div_sts.done) begin
						n_q <= n_next;
						if (!more_digits) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					idx_q <= n_q;
					if (too_long) begin
						reject_q <= 1'b1;
						state_q  <= S_SINGLE;
					end else if (conly_q) begin
						state_q <= S_SINGLE;
					end else if (neg_q) begin
						state_q <= S_SIGN;
					end else begin
						state_q <= S_DIGIT;
					end
				end
				S_SINGLE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				S_SIGN: begin
					if (emit) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (emit) begin
						idx_q <= idx_q - CNT_W'(1);
						if (item_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			base_q  <= req.base;
			cap_q   <= req.capacity;
			conly_q <= req.count_only;
		end
		if (emit) begin
			out_char_q   <= item_char;
			out_last_q   <= item_last;
			out_len_q    <= item_len;
			out_status_q <= item_status;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.char_code = out_char_q;
	assign rsp.is_last   = out_last_q;
	assign rsp.length    = out_len_q;
	assign rsp.status    = out_status_q;

	`ASSERT_CLK(a_start_when_free, clk, arst_n, div_ctl.start |-> !div_sts.busy, "divider busy")
	`ASSERT_NEVER(a_ready_not_dividing, clk, arst_n, req.ready && div_sts.busy, "ready while dividing")
	`ASSERT_CLK(a_last_to_idle, clk, arst_n, (emit && item_last) |=> (state_q == S_IDLE), "no idle")
	`ASSERT_CLK(a_count_bound, clk, arst_n, 1'b1 |-> (n_q <= CNT_W'(VALUE_BITS)), "count too big")

endmodule
